// ----- rtl/periodic_oneshot_timer_table_macros.svh -----
`ifndef PERIODIC_ONESHOT_TIMER_TABLE_MACROS_SVH
`define PERIODIC_ONESHOT_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define POTT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("timer table assertion failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define POTT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("timer table assertion failed");

`endif

// ----- rtl/pott_pkg.sv -----
`default_nettype none

package pott_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_64_W    = 64;

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [2:0] KIND_CREATED = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_REMOVED = 3'd2;
    localparam logic [2:0] KIND_FIRED   = 3'd3;
    localparam logic [2:0] KIND_IDLE    = 3'd4;

    typedef struct packed {
        logic                used;
        logic [CNT_64_W-1:0] rem;
        logic [CNT_64_W-1:0] rld;
    } slot_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/pott_cell.sv -----
`default_nettype none

module pott_cell
    import pott_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cell_ctrl_t          ctrl,
    input  wire slot_t               shift_in,
    input  wire logic [CNT_64_W-1:0] load_count,
    input  wire logic [CNT_64_W-1:0] load_interval,
    output slot_t                    state
);

    logic                used_reg;
    logic [CNT_64_W-1:0] rem_reg;
    logic [CNT_64_W-1:0] rld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else if (ctrl.shift) begin
            used_reg <= shift_in.used;
        end else if (ctrl.load) begin
            used_reg <= 1'b1;
        end else if (ctrl.clear) begin
            used_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            rem_reg <= shift_in.rem;
            rld_reg <= shift_in.rld;
        end else if (ctrl.load) begin
            rem_reg <= load_count;
            rld_reg <= load_interval;
        end
    end

    assign state.used = used_reg;
    assign state.rem  = rem_reg;
    assign state.rld  = rld_reg;

endmodule

`default_nettype wire

// ----- rtl/pott_update.sv -----
`default_nettype none

module pott_update
    import pott_pkg::*;
(
    input  wire slot_t               cur,
    input  wire logic [CNT_64_W-1:0] delta,
    output slot_t                    nxt,
    output logic                     fire
);

    assign fire     = cur.used && (cur.rem < delta);
    assign nxt.used = cur.used && !(fire && (cur.rld == '0));
    assign nxt.rem  = fire ? cur.rld : (cur.rem - delta);
    assign nxt.rld  = cur.rld;

endmodule

`default_nettype wire

// ----- rtl/periodic_oneshot_timer_table.sv -----
// Timer table: SLOTS timers, periodic or one-shot, one command item at a time.
// Input channel s_*: command create (claims lowest free slot, loads count and
// interval), remove (frees s_slot) or tick (s_elapsed nanoseconds passed).
// Result channel m_*: kind, slot_id and last; last marks the final result of
// an item. Create and remove give one result, registered on the cycle after
// the item is taken. Command code 3 is dropped with no result.
// A tick rotates the slot ring through one shared compare/subtract unit, one
// slot per cycle while no receiver stall holds it, then passes through a flush
// state that registers its last result; the next item is taken after the flush.
// Fired slots come out in ascending order, at most 16 per tick; a tick that
// fires nothing gives one idle result.
// s_ready is high only between items and while the result register can take
// a new result. A receiver stall holds m_* and freezes the tick walk on the
// slot that needs to report; nothing is lost or repeated.
// Reset (aresetn low, synchronous) frees every slot and empties the result
// register; slot counts and intervals keep no reset value.
`default_nettype none

module periodic_oneshot_timer_table
    import pott_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_command,
    input  wire logic [CNT_64_W-1:0] s_initial_count,
    input  wire logic [CNT_64_W-1:0] s_reload_interval,
    input  wire logic [3:0]          s_slot,
    input  wire logic [CNT_64_W-1:0] s_elapsed,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [2:0]               m_kind,
    output logic [3:0]               m_slot_id,
    output logic                     m_last
);

    localparam int CNT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SEL_W  = (CNT_W > 4) ? CNT_W + 1 : 5;
    localparam int FCNT_W = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_TICK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    step_reg, step_next;
    logic [CNT_64_W-1:0] delta_reg, delta_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [3:0]          pend_slot_reg, pend_slot_next;
    logic [FCNT_W-1:0]   fire_cnt_reg, fire_cnt_next;
    logic                m_valid_reg, m_valid_next;
    logic [2:0]          m_kind_reg, m_kind_next;
    logic [3:0]          m_slot_reg, m_slot_next;
    logic                m_last_reg, m_last_next;

    slot_t      cell_state [SLOTS];
    slot_t      head_next;
    logic       head_fire;
    cell_ctrl_t cell_ctrl  [SLOTS];

    logic             out_free;
    logic             accept;
    logic             any_free;
    logic [CNT_W-1:0] free_idx;
    logic [3:0]       free_id;
    logic [3:0]       step_id;
    logic [SEL_W-1:0] sel_ext;
    logic             do_shift;
    logic             do_load;
    logic             do_clear;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign sel_ext  = SEL_W'(s_slot);

    always_comb begin
        logic [CNT_W+3:0] wide_free;
        logic [CNT_W+3:0] wide_step;
        any_free = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!cell_state[i].used) begin
                any_free = 1'b1;
                free_idx = CNT_W'(i);
            end
        end
        wide_free = {4'b0, free_idx};
        wide_step = {4'b0, step_reg};
        free_id   = wide_free[3:0];
        step_id   = wide_step[3:0];
    end

    pott_update u_update (
        .cur   (cell_state[0]),
        .delta (delta_reg),
        .nxt   (head_next),
        .fire  (head_fire)
    );

    generate
        for (genvar k = 0; k < SLOTS; k++) begin : g_cell
            slot_t shift_src;
            if (k == SLOTS - 1) begin : g_tail
                assign shift_src = head_next;
            end else begin : g_body
                assign shift_src = cell_state[k+1];
            end
            assign cell_ctrl[k].shift = do_shift;
            assign cell_ctrl[k].load  = do_load && (free_idx == CNT_W'(k));
            assign cell_ctrl[k].clear = do_clear && (sel_ext == SEL_W'(k));
            pott_cell u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .ctrl          (cell_ctrl[k]),
                .shift_in      (shift_src),
                .load_count    (s_initial_count),
                .load_interval (s_reload_interval),
                .state         (cell_state[k])
            );
        end
    endgenerate

    always_comb begin
        logic report;
        state_next      = state_reg;
        step_next       = step_reg;
        delta_next      = delta_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        fire_cnt_next   = fire_cnt_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;
        m_kind_next     = m_kind_reg;
        m_slot_next     = m_slot_reg;
        m_last_next     = m_last_reg;
        do_shift        = 1'b0;
        do_load         = 1'b0;
        do_clear        = 1'b0;
        report          = head_fire && (fire_cnt_reg < FCNT_W'(MAX_RESULTS));

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_command)
                        CMD_CREATE: begin
                            m_valid_next = 1'b1;
                            m_last_next  = 1'b1;
                            if (any_free) begin
                                do_load     = 1'b1;
                                m_kind_next = KIND_CREATED;
                                m_slot_next = free_id;
                            end else begin
                                m_kind_next = KIND_FULL;
                                m_slot_next = '0;
                            end
                        end
                        CMD_REMOVE: begin
                            do_clear     = 1'b1;
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_REMOVED;
                            m_slot_next  = s_slot;
                            m_last_next  = 1'b1;
                        end
                        CMD_TICK: begin
                            delta_next      = s_elapsed;
                            step_next       = '0;
                            pend_valid_next = 1'b0;
                            fire_cnt_next   = '0;
                            state_next      = ST_TICK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TICK: begin
                if (!(report && pend_valid_reg) || out_free) begin
                    do_shift  = 1'b1;
                    step_next = step_reg + CNT_W'(1);
                    if (report) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_FIRED;
                            m_slot_next  = pend_slot_reg;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = step_id;
                        fire_cnt_next   = fire_cnt_reg + FCNT_W'(1);
                    end
                    if (step_reg == CNT_W'(SLOTS - 1)) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    m_kind_next  = pend_valid_reg ? KIND_FIRED : KIND_IDLE;
                    m_slot_next  = pend_valid_reg ? pend_slot_reg : 4'd0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            fire_cnt_reg   <= '0;
            step_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            fire_cnt_reg   <= fire_cnt_next;
            step_reg       <= step_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        delta_reg     <= delta_next;
        pend_slot_reg <= pend_slot_next;
        m_kind_reg    <= m_kind_next;
        m_slot_reg    <= m_slot_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_kind    = m_kind_reg;
    assign m_slot_id = m_slot_reg;
    assign m_last    = m_last_reg;

endmodule

`default_nettype wire

// ----- rtl/pott_checker.sv -----
`default_nettype none
`include "periodic_oneshot_timer_table_macros.svh"

module pott_checker
    import pott_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic [1:0]          s_command,
    input wire logic [CNT_64_W-1:0] s_initial_count,
    input wire logic [CNT_64_W-1:0] s_reload_interval,
    input wire logic [3:0]          s_slot,
    input wire logic [CNT_64_W-1:0] s_elapsed,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [2:0]          m_kind,
    input wire logic [3:0]          m_slot_id,
    input wire logic                m_last
);

    logic [7:0]            m_payload;
    logic [3*CNT_64_W+5:0] s_payload;
    logic                  zero_kind;

    assign m_payload = {m_kind, m_slot_id, m_last};
    assign s_payload = {s_command, s_initial_count, s_reload_interval, s_slot, s_elapsed};
    assign zero_kind = (m_kind == KIND_FULL) || (m_kind == KIND_IDLE);

    `POTT_ASSERT_NOW(a_kind_range, m_valid, m_kind <= KIND_IDLE)
    `POTT_ASSERT_NOW(a_single_last, m_valid && m_kind != KIND_FIRED, m_last)
    `POTT_ASSERT_NOW(a_zero_slot, m_valid && zero_kind, m_slot_id == 4'd0)
    `POTT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_payload))
    `POTT_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_payload))

endmodule

bind periodic_oneshot_timer_table pott_checker u_pott_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import pott_pkg::*;

    localparam logic [1:0] CMD_NOP      = 2'd3;
    localparam int         RANDOM_ITEMS = 190;
    localparam int         NUM_SLOTS    = SLOTS_DEF;
    localparam logic [CNT_64_W-1:0] CNT_MAX = '1;

    typedef struct {
        logic [1:0]          command;
        logic [CNT_64_W-1:0] initial_count;
        logic [CNT_64_W-1:0] reload_interval;
        logic [3:0]          slot;
        logic [CNT_64_W-1:0] elapsed;
        logic                wait_drain;
    } timer_cmd_t;

    typedef struct {
        logic [2:0] kind;
        logic [3:0] slot_id;
        logic       last;
    } timer_event_t;

    logic                aclk              = 1'b0;
    logic                aresetn           = 1'b0;
    logic                s_valid           = 1'b0;
    logic                s_ready;
    logic [1:0]          s_command         = CMD_NOP;
    logic [CNT_64_W-1:0] s_initial_count   = '0;
    logic [CNT_64_W-1:0] s_reload_interval = '0;
    logic [3:0]          s_slot            = '0;
    logic [CNT_64_W-1:0] s_elapsed         = '0;
    logic                m_valid;
    logic                m_ready           = 1'b0;
    logic [2:0]          m_kind;
    logic [3:0]          m_slot_id;
    logic                m_last;

    timer_cmd_t   pending_cmds[$];
    timer_event_t expected_events[$];

    logic                slot_used[NUM_SLOTS];
    logic [CNT_64_W-1:0] slot_remaining[NUM_SLOTS];
    logic [CNT_64_W-1:0] slot_reload[NUM_SLOTS];

    int err_count   = 0;
    int items_taken = 0;

    periodic_oneshot_timer_table u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_initial_count   (s_initial_count),
        .s_reload_interval (s_reload_interval),
        .s_slot            (s_slot),
        .s_elapsed         (s_elapsed),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_slot_id         (m_slot_id),
        .m_last            (m_last)
    );

    function automatic logic [CNT_64_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void push_event(logic [2:0] kind, logic [3:0] id, logic last);
        timer_event_t ev;
        ev.kind    = kind;
        ev.slot_id = id;
        ev.last    = last;
        expected_events.push_back(ev);
    endfunction

    function automatic void predict_timer_events(timer_cmd_t c);
        int  fired;
        logic found;
        fired = 0;
        found = 1'b0;
        case (c.command)
            CMD_CREATE: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!found && !slot_used[i]) begin
                        found             = 1'b1;
                        slot_used[i]      = 1'b1;
                        slot_remaining[i] = c.initial_count;
                        slot_reload[i]    = c.reload_interval;
                        push_event(KIND_CREATED, i[3:0], 1'b1);
                    end
                end
                if (!found) begin
                    push_event(KIND_FULL, 4'd0, 1'b1);
                end
            end
            CMD_REMOVE: begin
                if (int'(c.slot) < NUM_SLOTS) begin
                    slot_used[c.slot] = 1'b0;
                end
                push_event(KIND_REMOVED, c.slot, 1'b1);
            end
            CMD_TICK: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_used[i]) begin
                        if (slot_remaining[i] < c.elapsed) begin
                            slot_remaining[i] = slot_reload[i];
                            if (slot_reload[i] == '0) begin
                                slot_used[i] = 1'b0;
                            end
                            if (fired < MAX_RESULTS) begin
                                push_event(KIND_FIRED, i[3:0], 1'b0);
                                fired++;
                            end
                        end else begin
                            slot_remaining[i] = slot_remaining[i] - c.elapsed;
                        end
                    end
                end
                if (fired == 0) begin
                    push_event(KIND_IDLE, 4'd0, 1'b1);
                end else begin
                    expected_events[expected_events.size() - 1].last = 1'b1;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void queue_cmd(logic [1:0] command, logic [CNT_64_W-1:0] count,
                                      logic [CNT_64_W-1:0] interval, logic [3:0] slot,
                                      logic [CNT_64_W-1:0] elapsed, logic wait_drain);
        timer_cmd_t c;
        c.command         = command;
        c.initial_count   = count;
        c.reload_interval = interval;
        c.slot            = slot;
        c.elapsed         = elapsed;
        c.wait_drain      = wait_drain;
        pending_cmds.push_back(c);
    endfunction

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #(64'd20_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // sender: bursts of random length with random gaps
    always @(posedge aclk) begin : cmd_driver
        timer_cmd_t c;
        int         gap_left;
        int         burst_left;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            gap_left   = 0;
            burst_left = 0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_used[i] = 1'b0;
            end
        end else begin
            if (s_valid && s_ready) begin
                c.command         = s_command;
                c.initial_count   = s_initial_count;
                c.reload_interval = s_reload_interval;
                c.slot            = s_slot;
                c.elapsed         = s_elapsed;
                c.wait_drain      = 1'b0;
                predict_timer_events(c);
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() != 0 &&
                             !(pending_cmds[0].wait_drain && expected_events.size() != 0)) begin
                    c = pending_cmds.pop_front();
                    s_valid           <= 1'b1;
                    s_command         <= c.command;
                    s_initial_count   <= c.initial_count;
                    s_reload_interval <= c.reload_interval;
                    s_slot            <= c.slot;
                    s_elapsed         <= c.elapsed;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: own stall pattern plus long hold-offs
    always @(posedge aclk) begin : result_monitor
        timer_event_t want;
        logic [7:0]   stall_pat;
        int           pat_pos;
        int           hold_left;
        int           next_hold_at;
        if (!aresetn) begin
            m_ready      <= 1'b0;
            stall_pat    = 8'hFF;
            pat_pos      = 0;
            hold_left    = 0;
            next_hold_at = 60;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected result: kind %0d slot_id %0d last %0d",
                           m_kind, m_slot_id, m_last);
                    err_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (m_kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, m_kind);
                        err_count++;
                    end
                    if (m_slot_id !== want.slot_id) begin
                        $error("slot_id: expected %0d, actual %0d", want.slot_id, m_slot_id);
                        err_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, m_last);
                        err_count++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (items_taken >= next_hold_at && next_hold_at < 300) begin
                hold_left    = $urandom_range(200, 320);
                next_hold_at = next_hold_at + 110;
                m_ready <= 1'b0;
            end else begin
                m_ready <= stall_pat[pat_pos];
                pat_pos = (pat_pos + 1) % 8;
                if (pat_pos == 0) begin
                    stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
                end
            end
        end
    end

    initial begin
        int   random_items;
        int   pick;
        int   run_len;
        int   r;
        logic [CNT_64_W-1:0] count;
        logic [CNT_64_W-1:0] interval;
        logic [CNT_64_W-1:0] delta;

        // idle tick on empty table, extremes of count and interval
        queue_cmd(CMD_TICK,   rand64(), rand64(), 4'($urandom), CNT_MAX, 1'b0);
        queue_cmd(CMD_CREATE, '0, '0, 4'($urandom), rand64(), 1'b0);
        queue_cmd(CMD_CREATE, CNT_MAX, CNT_MAX, 4'($urandom), rand64(), 1'b0);
        queue_cmd(CMD_CREATE, 64'd5, '0, 4'($urandom), rand64(), 1'b0);
        // count equal to elapsed must not fire
        queue_cmd(CMD_TICK,   rand64(), rand64(), 4'($urandom), 64'd5, 1'b0);
        queue_cmd(CMD_TICK,   rand64(), rand64(), 4'($urandom), '0, 1'b0);
        queue_cmd(CMD_TICK,   rand64(), rand64(), 4'($urandom), 64'd1, 1'b0);
        // remove a free slot
        queue_cmd(CMD_REMOVE, rand64(), rand64(), 4'd15, rand64(), 1'b0);
        queue_cmd(CMD_NOP,    rand64(), rand64(), 4'($urandom), rand64(), 1'b0);
        queue_cmd(CMD_CREATE, 64'd3, 64'd7, 4'($urandom), rand64(), 1'b0);
        queue_cmd(CMD_TICK,   rand64(), rand64(), 4'($urandom), 64'd4, 1'b0);
        // fill the table, overflow once, then fire every slot
        for (int i = 0; i < NUM_SLOTS - 2; i++) begin
            queue_cmd(CMD_CREATE, 64'($urandom_range(0, 50)),
                      (i % 2 != 0) ? '0 : 64'($urandom_range(1, 60)),
                      4'($urandom), rand64(), 1'b0);
        end
        queue_cmd(CMD_CREATE, rand64(), rand64(), 4'($urandom), rand64(), 1'b0);
        queue_cmd(CMD_TICK,   rand64(), rand64(), 4'($urandom), CNT_MAX, 1'b0);

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            pick    = $urandom_range(0, 99);
            run_len = (pick < 15) ? $urandom_range(10, 18) : $urandom_range(1, 6);
            for (int k = 0; k < run_len; k++) begin
                count    = ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 300));
                r        = $urandom_range(0, 3);
                interval = (r == 0) ? '0 : (r == 3) ? rand64() : 64'($urandom_range(1, 200));
                r        = $urandom_range(0, 19);
                delta    = (r == 0) ? '0 : (r == 1) ? rand64() : (r == 2) ? CNT_MAX :
                           64'($urandom_range(1, 120));
                if (pick < 45) begin
                    queue_cmd(CMD_CREATE, count, interval, 4'($urandom), rand64(),
                              random_items == 0 || random_items == 110);
                end else if (pick < 60) begin
                    queue_cmd(CMD_REMOVE, rand64(), rand64(), 4'($urandom), rand64(),
                              random_items == 0 || random_items == 110);
                end else if (pick < 95) begin
                    queue_cmd(CMD_TICK, rand64(), rand64(), 4'($urandom), delta,
                              random_items == 0 || random_items == 110);
                end else begin
                    queue_cmd(CMD_NOP, count, interval, 4'($urandom), delta, 1'b0);
                    random_items--;
                end
                random_items++;
            end
        end

        @(posedge aclk);
        while (!aresetn || pending_cmds.size() != 0 || s_valid) @(posedge aclk);
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
